/* rtl/wfa_pkg.sv */
`default_nettype none

package wfa_pkg;

    // Fixed field widths.
    localparam int RANGE_W = 16;
    localparam int GAIN_W  = 16;
    localparam int SPEED_W = 9;
    localparam int HEAD_W  = 32;

    // Operand widths of the PID terms.
    localparam int ERR_W  = RANGE_W + 2;    // signed error or reading change, negated
    localparam int SUM_W  = HEAD_W + 1;     // signed error sum, negated
    localparam int PA_W   = GAIN_W + 1 + ERR_W;
    localparam int PB_W   = GAIN_W + 1 + SUM_W;
    localparam int ACC_W  = PB_W + 1;

    // Speeds and the avoidance turn (10 degrees in 1/4096 degree).
    localparam logic [SPEED_W-1:0]        ROAM_SPEED   = 9'd200;
    localparam logic [SPEED_W-1:0]        STOP_SPEED   = 9'd0;
    localparam logic signed [HEAD_W-1:0]  AVOID_TURN   = 32'sd40960;
    localparam logic signed [HEAD_W-1:0]  HEAD_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [HEAD_W-1:0]  HEAD_MIN     = 32'sh8000_0000;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  RST_P_GAIN     = 16'd82;
    localparam logic [GAIN_W-1:0]  RST_I_GAIN     = 16'd0;
    localparam logic [GAIN_W-1:0]  RST_D_GAIN     = 16'd4096;
    localparam logic [RANGE_W-1:0] RST_FOLLOW     = 16'd700;
    localparam logic [RANGE_W-1:0] RST_DETECT     = 16'd1000;
    localparam logic [RANGE_W-1:0] RST_AVOID      = 16'd650;
    localparam logic [RANGE_W-1:0] RST_ROAM       = 16'd1500;
    localparam logic [SPEED_W-1:0] RST_FAST_SPEED = 9'd250;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_P_GAIN          = 3'd0,
        CFG_I_GAIN          = 3'd1,
        CFG_D_GAIN          = 3'd2,
        CFG_FOLLOW_DISTANCE = 3'd3,
        CFG_DETECT_DISTANCE = 3'd4,
        CFG_AVOID_DISTANCE  = 3'd5,
        CFG_ROAM_LIMIT      = 3'd6,
        CFG_FAST_SPEED      = 3'd7
    } t_cfg_idx;

    // Steering modes.
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_LEFT   = 3'd1,
        MODE_RIGHT  = 3'd2,
        MODE_WANDER = 3'd3,
        MODE_AVOID  = 3'd4
    } t_mode;

    typedef struct packed {
        logic [RANGE_W-1:0] left_range;
        logic [RANGE_W-1:0] right_range;
        logic [RANGE_W-1:0] front_range;
        logic               obstacle_on_right;
    } t_in_item;

    typedef struct packed {
        logic [SPEED_W-1:0]        speed_cmd;
        logic signed [HEAD_W-1:0]  heading_delta;
        t_mode                     mode;
    } t_out_item;

    typedef struct packed {
        logic [GAIN_W-1:0]  p_gain;
        logic [GAIN_W-1:0]  i_gain;
        logic [GAIN_W-1:0]  d_gain;
        logic [RANGE_W-1:0] follow_distance;
        logic [RANGE_W-1:0] detect_distance;
        logic [RANGE_W-1:0] avoid_distance;
        logic [RANGE_W-1:0] roam_limit;
        logic [SPEED_W-1:0] fast_speed;
    } t_cfg;

    // Register load strobes.
    typedef struct packed {
        logic take;       // the item in the input register is processed this cycle
        logic out_load;
    } t_pipe_ctl;

    // Mode decision and PID operands handed to the PID datapath.
    typedef struct packed {
        logic                      use_pid;
        logic                      negate;
        logic signed [ERR_W-1:0]   err_op;
        logic signed [SUM_W-1:0]   sum_op;
        logic signed [ERR_W-1:0]   diff_op;
        logic [SPEED_W-1:0]        speed;
        logic signed [HEAD_W-1:0]  heading;
        t_mode                     mode;
    } t_stage1;

endpackage

`default_nettype wire

/* rtl/wfa_cfg_regs.sv */
`default_nettype none

module wfa_cfg_regs (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire wfa_pkg::t_cfg_idx    i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    output wfa_pkg::t_cfg             o_cfg
);
    import wfa_pkg::*;

    t_cfg r_cfg;

    // Register file, written one register per transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.p_gain          <= RST_P_GAIN;
            r_cfg.i_gain          <= RST_I_GAIN;
            r_cfg.d_gain          <= RST_D_GAIN;
            r_cfg.follow_distance <= RST_FOLLOW;
            r_cfg.detect_distance <= RST_DETECT;
            r_cfg.avoid_distance  <= RST_AVOID;
            r_cfg.roam_limit      <= RST_ROAM;
            r_cfg.fast_speed      <= RST_FAST_SPEED;
        end else if (i_cfg_valid && i_cfg_ready) begin
            case (i_cfg_index)
                CFG_P_GAIN:          r_cfg.p_gain          <= i_cfg_data;
                CFG_I_GAIN:          r_cfg.i_gain          <= i_cfg_data;
                CFG_D_GAIN:          r_cfg.d_gain          <= i_cfg_data;
                CFG_FOLLOW_DISTANCE: r_cfg.follow_distance <= i_cfg_data;
                CFG_DETECT_DISTANCE: r_cfg.detect_distance <= i_cfg_data;
                CFG_AVOID_DISTANCE:  r_cfg.avoid_distance  <= i_cfg_data;
                CFG_ROAM_LIMIT:      r_cfg.roam_limit      <= i_cfg_data;
                CFG_FAST_SPEED:      r_cfg.fast_speed      <= i_cfg_data[SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/wfa_decide.sv */
`default_nettype none

module wfa_decide (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire wfa_pkg::t_pipe_ctl   i_ctl,
    input  wire wfa_pkg::t_in_item    i_item,
    input  wire wfa_pkg::t_cfg        i_cfg,
    output wfa_pkg::t_stage1          o_s1
);
    import wfa_pkg::*;

    // Controller state.
    logic                      r_avoiding, n_avoiding;
    logic                      r_turn_locked, n_turn_locked;
    logic                      r_turn_right, n_turn_right;
    logic signed [HEAD_W-1:0]  r_error_sum, n_error_sum;
    logic [RANGE_W-1:0]        r_prior_reading, n_prior_reading;
    logic [SPEED_W-1:0]        r_speed, n_speed;
    t_stage1                   dec;

    logic                      fl, fr, wander, avoid, pid;
    logic [RANGE_W-1:0]        reading;
    logic signed [RANGE_W:0]   err, diff;
    logic signed [HEAD_W:0]    sum_wide;
    logic signed [HEAD_W-1:0]  sum_sat;
    logic signed [ERR_W-1:0]   err_ext, diff_ext;
    logic signed [SUM_W-1:0]   sum_ext;
    logic signed [HEAD_W-1:0]  turn_held, turn_new;

    // Mode choice, PID front end and the next state.
    always_comb begin
        fl = (i_item.left_range < i_cfg.detect_distance)
             && (i_item.left_range < i_item.right_range) && !r_avoiding;
        fr = (i_item.right_range < i_cfg.detect_distance)
             && (i_item.right_range < i_item.left_range) && !r_avoiding;
        pid = fl || fr;
        wander = !r_avoiding && !fl && !fr
                 && (i_item.front_range > i_cfg.roam_limit)
                 && (i_item.left_range > i_cfg.roam_limit)
                 && (i_item.right_range > i_cfg.roam_limit);
        avoid = i_item.front_range < i_cfg.avoid_distance;

        reading = fl ? i_item.left_range : i_item.right_range;
        err  = $signed({1'b0, i_cfg.follow_distance}) - $signed({1'b0, reading});
        diff = $signed({1'b0, reading}) - $signed({1'b0, r_prior_reading});

        // Error sum saturates to the signed 32-bit range.
        sum_wide = $signed({r_error_sum[HEAD_W-1], r_error_sum})
                   + $signed({{(HEAD_W-RANGE_W){err[RANGE_W]}}, err});
        if (sum_wide[HEAD_W] != sum_wide[HEAD_W-1]) begin
            sum_sat = sum_wide[HEAD_W] ? HEAD_MIN : HEAD_MAX;
        end else begin
            sum_sat = sum_wide[HEAD_W-1:0];
        end

        // Left following negates the PID result, so negate its operands here.
        err_ext  = $signed({err[RANGE_W], err});
        diff_ext = $signed({diff[RANGE_W], diff});
        sum_ext  = $signed({sum_sat[HEAD_W-1], sum_sat});

        turn_held = r_turn_right ? AVOID_TURN : -AVOID_TURN;
        turn_new  = i_item.obstacle_on_right ? AVOID_TURN : -AVOID_TURN;

        n_error_sum       = pid ? sum_sat : r_error_sum;
        n_prior_reading   = pid ? reading : r_prior_reading;
        n_avoiding        = avoid;
        n_turn_locked     = avoid;
        n_turn_right      = (avoid && !r_turn_locked) ? i_item.obstacle_on_right
                                                      : r_turn_right;

        if (avoid) begin
            n_speed = STOP_SPEED;
        end else if (wander) begin
            n_speed = ROAM_SPEED;
        end else if (pid) begin
            n_speed = i_cfg.fast_speed;
        end else begin
            n_speed = r_speed;
        end

        dec.use_pid = pid && !avoid;
        dec.negate  = fl;
        dec.err_op  = fl ? -err_ext : err_ext;
        dec.sum_op  = fl ? -sum_ext : sum_ext;
        dec.diff_op = fl ? -diff_ext : diff_ext;
        dec.speed   = n_speed;

        // A held turn stays out through the first clear tick after avoidance.
        if (r_avoiding) begin
            dec.heading = turn_held;
        end else if (avoid) begin
            dec.heading = turn_new;
        end else begin
            dec.heading = '0;
        end

        if (avoid) begin
            dec.mode = MODE_AVOID;
        end else if (wander) begin
            dec.mode = MODE_WANDER;
        end else if (fr) begin
            dec.mode = MODE_RIGHT;
        end else if (fl) begin
            dec.mode = MODE_LEFT;
        end else begin
            dec.mode = MODE_IDLE;
        end
    end

    // State advances once per item leaving the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avoiding        <= 1'b0;
            r_turn_locked     <= 1'b0;
            r_turn_right      <= 1'b0;
            r_error_sum       <= '0;
            r_prior_reading   <= '0;
            r_speed           <= ROAM_SPEED;
        end else if (i_ctl.take) begin
            r_avoiding        <= n_avoiding;
            r_turn_locked     <= n_turn_locked;
            r_turn_right      <= n_turn_right;
            r_error_sum       <= n_error_sum;
            r_prior_reading   <= n_prior_reading;
            r_speed           <= n_speed;
        end
    end

    assign o_s1 = dec;

endmodule

`default_nettype wire

/* rtl/wfa_pid.sv */
`default_nettype none

module wfa_pid (
    input  wire logic                 i_clk,
    input  wire wfa_pkg::t_pipe_ctl   i_ctl,
    input  wire wfa_pkg::t_stage1     i_s1,
    input  wire wfa_pkg::t_cfg        i_cfg,
    output wfa_pkg::t_out_item        o_item
);
    import wfa_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(HEAD_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(HEAD_MIN);

    logic signed [PA_W-1:0]    pa;
    logic signed [PB_W-1:0]    pb;
    logic signed [PA_W-1:0]    pc;
    t_out_item                 r_out, n_out;

    logic signed [ACC_W-1:0]   acc, acc_lo;
    logic signed [HEAD_W-1:0]  pid_sat;

    // Gain products, sum of terms and saturation; a negated result never
    // reaches the most negative value, it stops one above it.
    always_comb begin
        pa = $signed({1'b0, i_cfg.p_gain}) * i_s1.err_op;
        pb = $signed({1'b0, i_cfg.i_gain}) * i_s1.sum_op;
        pc = $signed({1'b0, i_cfg.d_gain}) * i_s1.diff_op;

        acc = $signed({{(ACC_W-PA_W){pa[PA_W-1]}}, pa})
              + $signed({{(ACC_W-PB_W){pb[PB_W-1]}}, pb})
              - $signed({{(ACC_W-PA_W){pc[PA_W-1]}}, pc});
        acc_lo = i_s1.negate ? ACC_MIN + ACC_W'(1) : ACC_MIN;
        if (acc > ACC_MAX) begin
            pid_sat = HEAD_MAX;
        end else if (acc < acc_lo) begin
            pid_sat = acc_lo[HEAD_W-1:0];
        end else begin
            pid_sat = acc[HEAD_W-1:0];
        end

        n_out.speed_cmd     = i_s1.speed;
        n_out.heading_delta = i_s1.use_pid ? pid_sat : i_s1.heading;
        n_out.mode          = i_s1.mode;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

`default_nettype wire

/* rtl/wall_follow_avoid_controller.sv */
`default_nettype none

// Steering controller for a sonar-equipped robot, one sensor reading per control
// tick. Each input transfer carries the left, right and front ranges and the side
// of the nearest frontal return; each produces exactly one result transfer with
// speed, heading change and mode, in input order. The block takes one item per
// clock cycle unless its input is stalled; each result passes through the two
// register stages (input, then result; the mode decision, error sum update, gain
// products and saturation all happen in one pass between them). While the result
// side stalls, an empty input register still takes one item, so input is stalled
// only when both registers are full. The configuration port is always ready; the
// user must write registers only while no item is in flight (not enforced here).
module wall_follow_avoid_controller (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire wfa_pkg::t_in_item    i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output wfa_pkg::t_out_item        o_out_item,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire wfa_pkg::t_cfg_idx    i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);
    import wfa_pkg::*;

    logic       r_in_valid, r_out_valid;
    t_in_item   r_in_item;
    logic       en_in, en_out;
    t_pipe_ctl  ctl;
    t_cfg       cfg;
    t_stage1    s1;

    // Each register moves when it is empty or its successor moves.
    always_comb begin
        en_out        = !r_out_valid || !i_out_stall;
        en_in         = !r_in_valid || en_out;
        ctl.take      = en_out && r_in_valid;
        ctl.out_load  = en_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (en_in) begin
                r_in_valid <= i_in_valid;
            end
            if (en_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_in_item <= i_in_item;
        end
    end

    assign o_in_stall  = !en_in;
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

    wfa_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wfa_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_item  (r_in_item),
        .i_cfg   (cfg),
        .o_s1    (s1)
    );

    wfa_pid u_pid (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_s1   (s1),
        .i_cfg  (cfg),
        .o_item (o_out_item)
    );

endmodule

`default_nettype wire
